FILE: rtl/dks_pkg.sv
// ----------------------------------------------------------------------------
// dks_pkg
// Shared types and constants for the descending key sorter.
// ----------------------------------------------------------------------------
`default_nettype none

package dks_pkg;

    // Record field widths.
    localparam int TAG_W = 16;
    localparam int KEY_W = 16;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,    // collect records from the input stream
        ST_ROW,     // fetch the head entry of the current row
        ST_SCAN,    // stream the later entries through the compare stage
        ST_DRAIN,   // let the last compare of the row finish
        ST_PUT,     // write the row winner back to its position
        ST_FETCH,   // read the next sorted record
        ST_SHOW     // present the record until the transaction completes
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_wr;  // store the incoming record at wr_addr
        logic rd_en;    // read the stores at rd_addr
        logic rd_cmp;   // the read feeds the compare stage
        logic rd_head;  // the read is the head entry of a row
        logic held_wr;  // write the held record at wr_addr
    } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/dks_datapath.sv
// ----------------------------------------------------------------------------
// dks_datapath
// Record stores, registered read port, and the compare and swap stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_datapath #(
    parameter int AW = 6
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire dks_pkg::cmd_t            cmd,
    input  wire logic [AW-1:0]            wr_addr,
    input  wire logic [AW-1:0]            rd_addr,
    input  wire logic [dks_pkg::TAG_W-1:0] in_tag,
    input  wire logic [dks_pkg::KEY_W-1:0] in_key,
    output logic      [dks_pkg::TAG_W-1:0] out_tag,
    output logic      [dks_pkg::KEY_W-1:0] out_key
);

    localparam int DEPTH = 1 << AW;

    // Record stores, one write and one read port.
    logic [dks_pkg::KEY_W-1:0] key_mem [DEPTH];
    logic [dks_pkg::TAG_W-1:0] tag_mem [DEPTH];

    logic [dks_pkg::KEY_W-1:0] rd_key_reg;
    logic [dks_pkg::TAG_W-1:0] rd_tag_reg;

    // Compare stage tracking, aligned with the read data.
    logic          p_valid_reg;
    logic          p_head_reg;
    logic [AW-1:0] p_addr_reg;

    // Running winner of the current row.
    logic [dks_pkg::KEY_W-1:0] held_key_reg;
    logic [dks_pkg::TAG_W-1:0] held_tag_reg;

    logic                      swap;
    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [dks_pkg::KEY_W-1:0] mem_wkey;
    logic [dks_pkg::TAG_W-1:0] mem_wtag;

    // A later entry with a strictly greater key displaces the held one.
    assign swap = p_valid_reg && !p_head_reg && (rd_key_reg > held_key_reg);

    // Write port selection: load, row write-back, or swap write.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = wr_addr;
        mem_wkey  = held_key_reg;
        mem_wtag  = held_tag_reg;
        if (cmd.load_wr) begin
            mem_we   = 1'b1;
            mem_wkey = in_key;
            mem_wtag = in_tag;
        end else if (cmd.held_wr) begin
            mem_we = 1'b1;
        end else if (swap) begin
            mem_we    = 1'b1;
            mem_waddr = p_addr_reg;
        end
    end

    // Store write and registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            key_mem[mem_waddr] <= mem_wkey;
            tag_mem[mem_waddr] <= mem_wtag;
        end
        if (cmd.rd_en) begin
            rd_key_reg <= key_mem[rd_addr];
            rd_tag_reg <= tag_mem[rd_addr];
        end
    end

    // Compare stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else begin
            p_valid_reg <= cmd.rd_en && cmd.rd_cmp;
        end
        p_head_reg <= cmd.rd_head;
        p_addr_reg <= rd_addr;
    end

    // Held record: loaded from the row head, replaced on each swap.
    always_ff @(posedge aclk) begin
        if ((p_valid_reg && p_head_reg) || swap) begin
            held_key_reg <= rd_key_reg;
            held_tag_reg <= rd_tag_reg;
        end
    end

    assign out_tag = rd_tag_reg;
    assign out_key = rd_key_reg;

endmodule

`default_nettype wire

FILE: rtl/dks_ctrl.sv
// ----------------------------------------------------------------------------
// dks_ctrl
// Sequencer for loading, exchange sorting and emitting the record list.
// ----------------------------------------------------------------------------
`default_nettype none

module dks_ctrl #(
    parameter int MAX_RECORDS = 64,
    parameter int AW          = 6,
    parameter int CW          = 7
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    input  wire logic          s_tlast,
    output logic               s_tready,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic               m_tlast,
    output logic               m_tuser,
    output dks_pkg::cmd_t      cmd,
    output logic [AW-1:0]      wr_addr,
    output logic [AW-1:0]      rd_addr
);

    dks_pkg::state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] k_reg, k_next;

    logic          space;
    logic [CW-1:0] n_after;
    logic [CW-1:0] cnt_m1;
    logic [AW-1:0] last_idx;
    logic          s_accept;

    assign space    = count_reg < CW'(MAX_RECORDS);
    assign n_after  = count_reg + CW'(space);
    assign cnt_m1   = count_reg - CW'(1);
    assign last_idx = cnt_m1[AW-1:0];
    assign s_accept = s_tvalid && s_tready;

    // State and counter registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dks_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    // Next state, counters and datapath commands.
    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cmd        = '0;
        wr_addr    = i_reg;
        rd_addr    = k_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        m_tlast    = 1'b0;
        m_tuser    = ovf_reg;
        case (state_reg)
            dks_pkg::ST_LOAD: begin
                // No transaction is taken while reset is held.
                s_tready = aresetn;
                wr_addr  = count_reg[AW-1:0];
                if (s_accept) begin
                    if (space) begin
                        cmd.load_wr = 1'b1;
                        count_next  = n_after;
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (s_tlast) begin
                        i_next = '0;
                        k_next = '0;
                        if (n_after >= CW'(2)) begin
                            state_next = dks_pkg::ST_ROW;
                        end else begin
                            state_next = dks_pkg::ST_FETCH;
                        end
                    end
                end
            end
            dks_pkg::ST_ROW: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_cmp  = 1'b1;
                cmd.rd_head = 1'b1;
                rd_addr     = i_reg;
                j_next      = i_reg + AW'(1);
                state_next  = dks_pkg::ST_SCAN;
            end
            dks_pkg::ST_SCAN: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_cmp = 1'b1;
                rd_addr    = j_reg;
                if (j_reg == last_idx) begin
                    state_next = dks_pkg::ST_DRAIN;
                end else begin
                    j_next = j_reg + AW'(1);
                end
            end
            dks_pkg::ST_DRAIN: begin
                state_next = dks_pkg::ST_PUT;
            end
            dks_pkg::ST_PUT: begin
                cmd.held_wr = 1'b1;
                if (CW'(i_reg) + CW'(2) == count_reg) begin
                    k_next     = '0;
                    state_next = dks_pkg::ST_FETCH;
                end else begin
                    i_next     = i_reg + AW'(1);
                    state_next = dks_pkg::ST_ROW;
                end
            end
            dks_pkg::ST_FETCH: begin
                cmd.rd_en  = 1'b1;
                state_next = dks_pkg::ST_SHOW;
            end
            dks_pkg::ST_SHOW: begin
                m_tvalid = 1'b1;
                m_tlast  = (k_reg == last_idx);
                if (m_tready) begin
                    if (k_reg == last_idx) begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = dks_pkg::ST_LOAD;
                    end else begin
                        k_next     = k_reg + AW'(1);
                        state_next = dks_pkg::ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = dks_pkg::ST_LOAD;
            end
        endcase
    end

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(MAX_RECORDS))
        else $error("record count beyond capacity");

    // The write port is never claimed twice in one cycle.
    a_one_writer: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load_wr && cmd.held_wr))
        else $error("load and row write-back collide");

    // A stalled result keeps its position in the list.
    a_show_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dks_pkg::ST_SHOW && !m_tready)
        |=> (state_reg == dks_pkg::ST_SHOW && $stable(k_reg)))
        else $error("stalled result moved");

    // A record taken at full capacity raises the overflow flag.
    a_ovf_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !space && !s_tlast) |=> ovf_reg)
        else $error("dropped record did not set overflow");

    // No input is taken while results are pending.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output active together");

endmodule

`default_nettype wire

FILE: rtl/descending_key_sorter_core.sv
// ----------------------------------------------------------------------------
// descending_key_sorter_core
// Loads a list of tagged records, exchange sorts it by descending key and
// streams the sorted records out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   s_       in         tdata: tag, sort_key; tlast: last_item
//   m_       out        tdata: out_tag, out_key; tlast: last_result;
//                       tuser: overflow
//
// Loading accepts one record per cycle. After the closing record, the list
// is sorted row by row through the single compare stage on the record
// store's one read port, then each record is emitted through a fetch state
// and a show state. Reset is synchronous and needs no store clearing pass;
// s_tready is low during reset and the first record can be taken right after
// release. s_tready is low while sorting and emitting; a stalled m_
// transaction simply holds its record.
// ----------------------------------------------------------------------------
`default_nettype none

module descending_key_sorter_core #(
    parameter int MAX_RECORDS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [15:0] tag, [31:16] sort_key
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // [15:0] out_tag, [31:16] out_key
    output logic             m_tlast,
    output logic             m_tuser    // [0] overflow
);

    localparam int AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);

    dks_pkg::cmd_t cmd;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;
    logic [dks_pkg::TAG_W-1:0] out_tag;
    logic [dks_pkg::KEY_W-1:0] out_key;

    // Sequencer.
    dks_ctrl #(
        .MAX_RECORDS (MAX_RECORDS),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .wr_addr  (wr_addr),
        .rd_addr  (rd_addr)
    );

    // Record stores and compare stage.
    dks_datapath #(
        .AW (AW)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .in_tag  (s_tdata[15:0]),
        .in_key  (s_tdata[31:16]),
        .out_tag (out_tag),
        .out_key (out_key)
    );

    assign m_tdata = {out_key, out_tag};

endmodule

`default_nettype wire
